// ===== sv/rtcm3fd_pkg.sv =====
// Package for the RTCM3-style frame delimiter: phase codes, register indexes,
// widths and the result record shared by the parser, output stage and top level.
// No dependencies.
package rtcm3fd_pkg;

    localparam int COUNT_BITS = 11;
    localparam int LEN_BITS   = 10;
    localparam int LIMIT_BITS = 11;
    localparam int IDX_BITS   = 2;
    localparam int CFG_BITS   = 11;

    localparam logic [7:0]            START_RESET = 8'hD3;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 11'd1029;
    localparam logic [COUNT_BITS-1:0] HEAD_BYTES  = COUNT_BITS'(3);

    localparam logic [IDX_BITS-1:0] REG_PREAMBLE    = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_LIMIT = 2'd1;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_HEADER  = 7'b0000010,
        PH_LENLOW  = 7'b0000100,
        PH_PAYLOAD = 7'b0001000,
        PH_CHECK1  = 7'b0010000,
        PH_CHECK2  = 7'b0100000,
        PH_CHECK3  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        in_frame;
        logic        frame_start;
        logic        frame_done;
        logic        frame_error;
        logic [10:0] frame_bytes;
        logic [23:0] check_word;
        logic [15:0] error_count;
        logic        busy_res;
    } t_result;

endpackage

// ===== sv/rtcm3fd_in_stage.sv =====
// Input register of the frame delimiter: holds one received byte until the
// parser takes it. Depends on nothing but the clock and reset.
module rtcm3fd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== sv/rtcm3fd_parser.sv =====
// Frame parser: phase machine, byte and length counters, check bytes and the
// abort counter. Builds one result per byte. Uses rtcm3fd_pkg.
module rtcm3fd_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [7:0]                          i_byte,
    input  logic [7:0]                          i_preamble,
    input  logic [rtcm3fd_pkg::LIMIT_BITS-1:0]  i_frame_limit,
    output rtcm3fd_pkg::t_result                o_result
);

    rtcm3fd_pkg::t_phase                   r_phase, n_phase;
    logic [rtcm3fd_pkg::COUNT_BITS-1:0]    r_byte_count, n_byte_count;
    logic [rtcm3fd_pkg::LEN_BITS-1:0]      r_payload_length, n_payload_length;
    logic [7:0]                            r_previous_byte;
    logic [7:0]                            r_check_high, n_check_high;
    logic [7:0]                            r_check_middle, n_check_middle;
    logic [15:0]                           r_abort_count, n_abort_count;

    logic [rtcm3fd_pkg::COUNT_BITS-1:0]    count_inc;
    logic [rtcm3fd_pkg::COUNT_BITS-1:0]    limit_ext;
    logic [rtcm3fd_pkg::COUNT_BITS-1:0]    len_ext;
    logic [rtcm3fd_pkg::COUNT_BITS-1:0]    body_count;
    logic [rtcm3fd_pkg::LEN_BITS-1:0]      new_length;
    logic                                  abort;

    assign count_inc  = r_byte_count + 1'b1;
    assign limit_ext  = rtcm3fd_pkg::COUNT_BITS'(i_frame_limit);
    assign len_ext    = rtcm3fd_pkg::COUNT_BITS'(r_payload_length);
    assign body_count = count_inc - rtcm3fd_pkg::HEAD_BYTES;
    assign new_length = {r_previous_byte[1:0], i_byte};

    always_comb begin
        n_phase          = r_phase;
        n_byte_count     = count_inc;
        n_payload_length = r_payload_length;
        n_check_high     = r_check_high;
        n_check_middle   = r_check_middle;
        abort            = 1'b0;
        o_result             = '0;
        o_result.out_byte    = i_byte;
        o_result.in_frame    = 1'b1;
        unique case (r_phase)
            rtcm3fd_pkg::PH_IDLE: begin
                n_byte_count = '0;
                if (i_byte == i_preamble) begin
                    n_phase              = rtcm3fd_pkg::PH_HEADER;
                    n_payload_length     = '0;
                    n_check_high         = '0;
                    n_check_middle       = '0;
                    n_byte_count         = rtcm3fd_pkg::COUNT_BITS'(1);
                    o_result.frame_start = 1'b1;
                end else begin
                    o_result.in_frame = 1'b0;
                end
            end
            rtcm3fd_pkg::PH_HEADER: begin
                n_phase = rtcm3fd_pkg::PH_LENLOW;
            end
            rtcm3fd_pkg::PH_LENLOW: begin
                n_payload_length = new_length;
                if (new_length == '0 ||
                    rtcm3fd_pkg::COUNT_BITS'(new_length) > limit_ext) begin
                    abort = 1'b1;
                end else begin
                    n_phase = rtcm3fd_pkg::PH_PAYLOAD;
                end
            end
            rtcm3fd_pkg::PH_PAYLOAD: begin
                if (count_inc >= rtcm3fd_pkg::HEAD_BYTES && body_count > len_ext) begin
                    abort = 1'b1;
                end else if (count_inc >= rtcm3fd_pkg::HEAD_BYTES &&
                             body_count == len_ext) begin
                    n_phase = rtcm3fd_pkg::PH_CHECK1;
                end
            end
            rtcm3fd_pkg::PH_CHECK1: begin
                n_check_high = i_byte;
                n_phase      = rtcm3fd_pkg::PH_CHECK2;
            end
            rtcm3fd_pkg::PH_CHECK2: begin
                n_check_middle = i_byte;
                n_phase        = rtcm3fd_pkg::PH_CHECK3;
            end
            rtcm3fd_pkg::PH_CHECK3: begin
                if (count_inc > limit_ext) begin
                    abort = 1'b1;
                end else begin
                    n_phase              = rtcm3fd_pkg::PH_IDLE;
                    o_result.frame_done  = 1'b1;
                    o_result.frame_bytes = count_inc[10:0];
                    o_result.check_word  = {r_check_high, r_check_middle, i_byte};
                end
            end
            default: begin
                abort = 1'b1;
            end
        endcase

        n_abort_count = r_abort_count;
        if (abort) begin
            n_phase              = rtcm3fd_pkg::PH_IDLE;
            o_result.frame_error = 1'b1;
            if (r_abort_count != '1) begin
                n_abort_count = r_abort_count + 1'b1;
            end
        end
        o_result.error_count = n_abort_count;
        o_result.busy_res    = (n_phase != rtcm3fd_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= rtcm3fd_pkg::PH_IDLE;
            r_byte_count     <= '0;
            r_payload_length <= '0;
            r_previous_byte  <= '0;
            r_check_high     <= '0;
            r_check_middle   <= '0;
            r_abort_count    <= '0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_byte_count     <= n_byte_count;
            r_payload_length <= n_payload_length;
            r_previous_byte  <= i_byte;
            r_check_high     <= n_check_high;
            r_check_middle   <= n_check_middle;
            r_abort_count    <= n_abort_count;
        end
    end

endmodule

// ===== sv/rtcm3fd_out_reg.sv =====
// Result register of the frame delimiter: holds one result until the
// downstream side takes it. Uses rtcm3fd_pkg for the result record.
module rtcm3fd_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  rtcm3fd_pkg::t_result  i_result,
    output logic                  o_valid,
    input  logic                  i_ready,
    output rtcm3fd_pkg::t_result  o_result
);

    logic                  r_valid;
    rtcm3fd_pkg::t_result  r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== sv/rtcm3_frame_delimiter.sv =====
// Top level of the RTCM3-style frame delimiter: configuration registers and
// the input stage, parser and result register. Uses rtcm3fd_pkg.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] = in_byte
//  m_axis    out        tdata, tuser, tlast = one result per byte
//  cfg       in         index 0 = preamble byte, index 1 = frame_limit
//
// Every byte passes from input to output through the input register and the
// result register, and one byte is taken in every cycle while the master side does not stall.
// The phase machine and counters update in the single cycle that moves a byte
// from the input register into the result register.
// Reset is synchronous; it loads 0xD3 and 1029 into the registers.
// A stall on the master side holds the result and backs up to s_axis.
module rtcm3_frame_delimiter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] in_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [7:0] out_byte, [18:8] frame_bytes, [42:19] check_word,
    // [58:43] error_count, [59] busy_res, [63:60] zero
    output logic [63:0]                       o_m_tdata,
    output logic [2:0]                        o_m_tuser,   // [0] in_frame, [1] frame_start,
                                                           // [2] frame_error
    output logic                              o_m_tlast,   // frame_done
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rtcm3fd_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [rtcm3fd_pkg::CFG_BITS-1:0]  i_cfg_data
);

    logic [7:0]                           r_preamble;
    logic [rtcm3fd_pkg::LIMIT_BITS-1:0]   r_frame_limit;

    logic                  in_valid;
    logic [7:0]            in_byte;
    logic                  out_ready;
    logic                  step;
    rtcm3fd_pkg::t_result  parse_result;
    rtcm3fd_pkg::t_result  out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble    <= rtcm3fd_pkg::START_RESET;
            r_frame_limit <= rtcm3fd_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rtcm3fd_pkg::REG_PREAMBLE:    r_preamble    <= i_cfg_data[7:0];
                rtcm3fd_pkg::REG_FRAME_LIMIT: r_frame_limit <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    assign step = in_valid && out_ready;

    rtcm3fd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .i_take  (out_ready)
    );

    rtcm3fd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_byte        (in_byte),
        .i_preamble    (r_preamble),
        .i_frame_limit (r_frame_limit),
        .o_result      (parse_result)
    );

    rtcm3fd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .o_ready  (out_ready),
        .i_result (parse_result),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    assign o_m_tdata = {4'b0000, out_result.busy_res, out_result.error_count,
                        out_result.check_word, out_result.frame_bytes,
                        out_result.out_byte};
    assign o_m_tuser = {out_result.frame_error, out_result.frame_start,
                        out_result.in_frame};
    assign o_m_tlast = out_result.frame_done;

endmodule
